### rtl/snapshot_stream_parser_crc64_assert.svh
// assertion macros for the snapshot stream parser checker
// no dependencies
`ifndef SNAPSHOT_STREAM_PARSER_CRC64_ASSERT_SVH
`define SNAPSHOT_STREAM_PARSER_CRC64_ASSERT_SVH
// implication checked on every edge outside reset
`define SSP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define SSP_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

### rtl/ssp_pkg.sv
// types, codes and crc function for the snapshot stream parser
// no dependencies
package ssp_pkg;

    localparam logic [63:0] CRC_POLY = 64'had93d23594c935a9;

    localparam logic [4:0] PH_MAGIC     = 5'd0;
    localparam logic [4:0] PH_VERSION   = 5'd1;
    localparam logic [4:0] PH_KEYCOUNT  = 5'd2;
    localparam logic [4:0] PH_TYPE      = 5'd3;
    localparam logic [4:0] PH_EXPIRY    = 5'd4;
    localparam logic [4:0] PH_KEYLEN    = 5'd5;
    localparam logic [4:0] PH_KEYBYTE   = 5'd6;
    localparam logic [4:0] PH_VALLEN    = 5'd7;
    localparam logic [4:0] PH_VALBYTE   = 5'd8;
    localparam logic [4:0] PH_COUNT     = 5'd9;
    localparam logic [4:0] PH_ELEMLEN   = 5'd10;
    localparam logic [4:0] PH_ELEMBYTE  = 5'd11;
    localparam logic [4:0] PH_FIELDLEN  = 5'd12;
    localparam logic [4:0] PH_FIELDBYTE = 5'd13;
    localparam logic [4:0] PH_SCORE     = 5'd14;
    localparam logic [4:0] PH_CRC       = 5'd15;
    localparam logic [4:0] PH_DONE      = 5'd16;

    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_LIST   = 2'd1;
    localparam logic [1:0] KIND_HASH   = 2'd2;
    localparam logic [1:0] KIND_ZSET   = 2'd3;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BAD_MAG  = 3'd2;
    localparam logic [2:0] ST_BAD_VER  = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE = 3'd4;
    localparam logic [2:0] ST_BAD_CRC  = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;

    localparam logic [2:0] CFG_MAGIC   = 3'd0;
    localparam logic [2:0] CFG_VERSION = 3'd1;
    localparam logic [2:0] CFG_T_STR   = 3'd2;
    localparam logic [2:0] CFG_T_LIST  = 3'd3;
    localparam logic [2:0] CFG_T_HASH  = 3'd4;
    localparam logic [2:0] CFG_T_ZSET  = 3'd5;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [4:0]  role;
        logic [7:0]  data_out;
        logic        field_last;
        logic [63:0] field_value;
        logic [2:0]  status;
    } t_out;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [31:0] format_version;
        logic [7:0]  t_str;
        logic [7:0]  t_list;
        logic [7:0]  t_hash;
        logic [7:0]  t_zset;
    } t_cfg;

    // one byte of the reflected crc, eight bit steps
    function automatic logic [63:0] crc_byte(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/ssp_cfg_regs.sv
// configuration register file of the snapshot stream parser
// depends on ssp_pkg
module ssp_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output ssp_pkg::t_cfg        o_cfg
);
    ssp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word     <= 32'd0;
            r_cfg.format_version <= 32'd1;
            r_cfg.t_str          <= 8'd0;
            r_cfg.t_list         <= 8'd1;
            r_cfg.t_hash         <= 8'd2;
            r_cfg.t_zset         <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssp_pkg::CFG_MAGIC:   r_cfg.magic_word     <= i_cfg_data;
                ssp_pkg::CFG_VERSION: r_cfg.format_version <= i_cfg_data;
                ssp_pkg::CFG_T_STR:   r_cfg.t_str          <= i_cfg_data[7:0];
                ssp_pkg::CFG_T_LIST:  r_cfg.t_list         <= i_cfg_data[7:0];
                ssp_pkg::CFG_T_HASH:  r_cfg.t_hash         <= i_cfg_data[7:0];
                ssp_pkg::CFG_T_ZSET:  r_cfg.t_zset         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/ssp_parser.sv
// parse state machine and crc accumulator, one byte per step
// depends on ssp_pkg
module ssp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  ssp_pkg::t_in   i_item,
    input  ssp_pkg::t_cfg  i_cfg,
    output ssp_pkg::t_out  o_res
);
    logic [4:0]  r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [63:0] r_shift, n_shift;
    logic [63:0] r_keys, n_keys;
    logic [31:0] r_elems, n_elems;
    logic [31:0] r_blob, n_blob;
    logic [1:0]  r_kind, n_kind;
    logic        r_half, n_half;
    logic [63:0] r_crc, n_crc;
    logic [2:0]  r_status, n_status;

    logic [63:0] v;
    logic [3:0]  width;
    logic [63:0] keys_m1;
    logic [31:0] elems_m1;
    logic [31:0] blob_m1;
    logic [4:0]  item_ph;
    logic [4:0]  entry_ph;
    logic [7:0]  b;

    always_comb begin
        b        = i_item.data_in;
        keys_m1  = r_keys - 64'd1;
        elems_m1 = r_elems - 32'd1;
        blob_m1  = r_blob - 32'd1;
        v        = r_shift | ({56'd0, b} << {r_cnt, 3'b000});
        entry_ph = (keys_m1 == 64'd0) ? ssp_pkg::PH_CRC : ssp_pkg::PH_TYPE;
        case (r_kind)
            ssp_pkg::KIND_LIST: item_ph = ssp_pkg::PH_ELEMLEN;
            ssp_pkg::KIND_HASH: item_ph = ssp_pkg::PH_FIELDLEN;
            default:            item_ph = ssp_pkg::PH_SCORE;
        endcase
        case (r_phase)
            ssp_pkg::PH_TYPE: width = 4'd1;
            ssp_pkg::PH_KEYCOUNT, ssp_pkg::PH_EXPIRY,
            ssp_pkg::PH_SCORE, ssp_pkg::PH_CRC: width = 4'd8;
            default: width = 4'd4;
        endcase

        n_phase = r_phase; n_cnt = r_cnt; n_shift = r_shift; n_keys = r_keys;
        n_elems = r_elems; n_blob = r_blob; n_kind = r_kind; n_half = r_half;
        n_crc = r_crc; n_status = r_status;

        o_res.role        = ssp_pkg::PH_DONE;
        o_res.data_out    = i_item.end_of_input ? 8'd0 : b;
        o_res.field_last  = 1'b0;
        o_res.field_value = 64'd0;

        if (r_status != ssp_pkg::ST_BUSY || r_phase >= ssp_pkg::PH_DONE) begin
            // sticky end state
        end else if (i_item.end_of_input) begin
            case (r_phase)
                ssp_pkg::PH_MAGIC:   n_status = ssp_pkg::ST_BAD_MAG;
                ssp_pkg::PH_VERSION: n_status = ssp_pkg::ST_BAD_VER;
                ssp_pkg::PH_CRC:     n_status = ssp_pkg::ST_BAD_CRC;
                default:             n_status = ssp_pkg::ST_TRUNC;
            endcase
            n_phase = ssp_pkg::PH_DONE;
        end else begin
            o_res.role = r_phase;
            if (r_phase != ssp_pkg::PH_CRC) n_crc = ssp_pkg::crc_byte(r_crc, b);
            if (r_phase == ssp_pkg::PH_KEYBYTE || r_phase == ssp_pkg::PH_VALBYTE ||
                r_phase == ssp_pkg::PH_ELEMBYTE || r_phase == ssp_pkg::PH_FIELDBYTE) begin
                n_blob = blob_m1;
                if (blob_m1 == 32'd0) begin
                    o_res.field_last = 1'b1;
                    // end of blob
                    case (r_phase)
                        ssp_pkg::PH_KEYBYTE: begin
                            n_phase = (r_kind == ssp_pkg::KIND_STRING) ?
                                      ssp_pkg::PH_VALLEN : ssp_pkg::PH_COUNT;
                        end
                        ssp_pkg::PH_VALBYTE: begin
                            if (r_kind == ssp_pkg::KIND_HASH) begin
                                n_half  = 1'b0;
                                n_elems = elems_m1;
                                if (elems_m1 == 32'd0) begin
                                    n_keys = keys_m1; n_phase = entry_ph;
                                end else n_phase = item_ph;
                            end else begin
                                n_keys = keys_m1; n_phase = entry_ph;
                            end
                        end
                        ssp_pkg::PH_FIELDBYTE: begin
                            n_half = 1'b1; n_phase = ssp_pkg::PH_VALLEN;
                        end
                        default: begin
                            n_elems = elems_m1;
                            if (elems_m1 == 32'd0) begin
                                n_keys = keys_m1; n_phase = entry_ph;
                            end else n_phase = item_ph;
                        end
                    endcase
                end
            end else if ({1'b0, r_cnt} + 4'd1 < width) begin
                n_shift = v;
                n_cnt   = r_cnt + 3'd1;
            end else begin
                n_shift = 64'd0;
                n_cnt   = 3'd0;
                o_res.field_last  = 1'b1;
                o_res.field_value = v;
                case (r_phase)
                    ssp_pkg::PH_MAGIC: begin
                        if (v[31:0] != i_cfg.magic_word) begin
                            n_status = ssp_pkg::ST_BAD_MAG; n_phase = ssp_pkg::PH_DONE;
                        end else n_phase = ssp_pkg::PH_VERSION;
                    end
                    ssp_pkg::PH_VERSION: begin
                        if (v[31:0] != i_cfg.format_version) begin
                            n_status = ssp_pkg::ST_BAD_VER; n_phase = ssp_pkg::PH_DONE;
                        end else n_phase = ssp_pkg::PH_KEYCOUNT;
                    end
                    ssp_pkg::PH_KEYCOUNT: begin
                        n_keys  = v;
                        n_phase = (v == 64'd0) ? ssp_pkg::PH_CRC : ssp_pkg::PH_TYPE;
                    end
                    ssp_pkg::PH_TYPE: begin
                        n_half  = 1'b0;
                        n_phase = ssp_pkg::PH_EXPIRY;
                        if (v[7:0] == i_cfg.t_str)       n_kind = ssp_pkg::KIND_STRING;
                        else if (v[7:0] == i_cfg.t_list) n_kind = ssp_pkg::KIND_LIST;
                        else if (v[7:0] == i_cfg.t_hash) n_kind = ssp_pkg::KIND_HASH;
                        else if (v[7:0] == i_cfg.t_zset) n_kind = ssp_pkg::KIND_ZSET;
                        else begin
                            n_half   = r_half;
                            n_status = ssp_pkg::ST_BAD_TYPE;
                            n_phase  = ssp_pkg::PH_DONE;
                        end
                    end
                    ssp_pkg::PH_EXPIRY: n_phase = ssp_pkg::PH_KEYLEN;
                    ssp_pkg::PH_KEYLEN, ssp_pkg::PH_VALLEN,
                    ssp_pkg::PH_ELEMLEN, ssp_pkg::PH_FIELDLEN: begin
                        n_blob = v[31:0];
                        if (v[31:0] != 32'd0) n_phase = r_phase + 5'd1;
                        else begin
                            // empty blob: same exit as its last byte
                            case (r_phase)
                                ssp_pkg::PH_KEYLEN: begin
                                    n_phase = (r_kind == ssp_pkg::KIND_STRING) ?
                                              ssp_pkg::PH_VALLEN : ssp_pkg::PH_COUNT;
                                end
                                ssp_pkg::PH_VALLEN: begin
                                    if (r_kind == ssp_pkg::KIND_HASH) begin
                                        n_half  = 1'b0;
                                        n_elems = elems_m1;
                                        if (elems_m1 == 32'd0) begin
                                            n_keys = keys_m1; n_phase = entry_ph;
                                        end else n_phase = item_ph;
                                    end else begin
                                        n_keys = keys_m1; n_phase = entry_ph;
                                    end
                                end
                                ssp_pkg::PH_FIELDLEN: begin
                                    n_half = 1'b1; n_phase = ssp_pkg::PH_VALLEN;
                                end
                                default: begin
                                    n_elems = elems_m1;
                                    if (elems_m1 == 32'd0) begin
                                        n_keys = keys_m1; n_phase = entry_ph;
                                    end else n_phase = item_ph;
                                end
                            endcase
                        end
                    end
                    ssp_pkg::PH_COUNT: begin
                        n_elems = v[31:0];
                        if (v[31:0] == 32'd0) begin
                            n_keys = keys_m1; n_phase = entry_ph;
                        end else n_phase = item_ph;
                    end
                    ssp_pkg::PH_SCORE: n_phase = ssp_pkg::PH_ELEMLEN;
                    default: begin
                        n_status = (v == r_crc) ? ssp_pkg::ST_OK : ssp_pkg::ST_BAD_CRC;
                        n_phase  = ssp_pkg::PH_DONE;
                    end
                endcase
            end
        end
        o_res.status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ssp_pkg::PH_MAGIC; r_cnt <= 3'd0; r_shift <= 64'd0;
            r_keys <= 64'd0; r_elems <= 32'd0; r_blob <= 32'd0;
            r_kind <= ssp_pkg::KIND_STRING; r_half <= 1'b0; r_crc <= 64'd0;
            r_status <= ssp_pkg::ST_BUSY;
        end else if (i_step) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_shift <= n_shift;
            r_keys <= n_keys; r_elems <= n_elems; r_blob <= n_blob;
            r_kind <= n_kind; r_half <= n_half; r_crc <= n_crc;
            r_status <= n_status;
        end
    end
endmodule

### rtl/snapshot_stream_parser_crc64.sv
// top level of the snapshot stream parser with crc-64 check
// depends on ssp_pkg, ssp_cfg_regs, ssp_parser
//
// usage:
// - input channel: one file byte (or an end marker) per transaction on
//   i_in_valid / o_in_stall, payload i_in_data
// - output channel: one tagged byte per input transaction on o_out_valid /
//   i_out_stall, payload o_out_data (role, byte, last flag, value, status)
// - config: i_cfg_we, i_cfg_index, i_cfg_data write one register per edge
// - result timing: the result of a byte is registered and valid in the cycle after its acceptance
// - throughput: one byte per cycle unless a held result is stalled; the
//   parser state and the byte-wide crc step are updated in the accepting
//   cycle, the result lands in one output register
// - when the receiver stalls, the output register holds and input stalls
//   only while the held result cannot move on the same edge
// - reset clears the parse state, the crc, the status and the registers
//   to their defaults; the output register comes up empty
module snapshot_stream_parser_crc64 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ssp_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ssp_pkg::t_out  o_out_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    ssp_pkg::t_cfg cfg;
    ssp_pkg::t_out res;
    ssp_pkg::t_out r_out;
    logic          r_valid;
    logic          accept;

    // input stalls only while a held result is stuck
    assign o_in_stall = r_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    ssp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_item  (i_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;
endmodule

### rtl/ssp_checker.sv
// port-level checker for the snapshot stream parser, bound to the top level
// depends on ssp_pkg and snapshot_stream_parser_crc64_assert.svh
`include "snapshot_stream_parser_crc64_assert.svh"
module ssp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ssp_pkg::t_out o_out_data
);
    logic in_acc;
    logic out_acc;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // every accepted byte shows up as a result next cycle
    `SSP_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, in_acc, o_out_valid, "result missing")
    // a stalled result holds
    `SSP_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled result changed")
    // a result tagged done carries a final status and no last flag
    `SSP_ASSERT_IMP(a_ignored, i_clk, i_rst_n,
        o_out_valid && o_out_data.role == ssp_pkg::PH_DONE,
        o_out_data.status != ssp_pkg::ST_BUSY && !o_out_data.field_last, "bad ignored")
    // stall only while a result is held
    `SSP_ASSERT_IMP(a_stall, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall,
        "spurious input stall")
    // no result without source when drained
    `SSP_ASSERT_NXT(a_drain, i_clk, i_rst_n, out_acc && !in_acc, !o_out_valid,
        "result invented")
endmodule

bind snapshot_stream_parser_crc64 ssp_checker u_ssp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### test/tb_snapshot_stream_parser_crc64.sv
// testbench for snapshot_stream_parser_crc64: streams one snapshot file, checks every tagged byte
// depends on ssp_pkg and the snapshot_stream_parser_crc64 rtl
module tb_snapshot_stream_parser_crc64;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DIRECTED_ENTRIES = 7;
    localparam int RANDOM_ENTRIES = 24;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    ssp_pkg::t_in  in_item = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    ssp_pkg::t_out out_item;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = ssp_pkg::CFG_MAGIC;
    logic [31:0]   cfg_data = '0;

    snapshot_stream_parser_crc64 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // idling percentages for the current phase
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;

    int cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int tags_checked = 0;

    ssp_pkg::t_out tagged_q[$];

    // ---------------- predictor state ----------------
    ssp_pkg::t_cfg cfg_copy;
    logic [4:0]    m_phase;
    logic [3:0]    m_fcnt;
    logic [63:0]   m_fshift;
    logic [63:0]   m_keys;
    logic [31:0]   m_elems;
    logic [31:0]   m_blob;
    logic [1:0]    m_kind;
    logic          m_val_due;
    logic [63:0]   m_crc;
    logic [2:0]    m_status;

    function automatic logic [63:0] crc64_step(logic [63:0] c, logic [7:0] b);
        logic [63:0] r;
        r = c ^ {56'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) r = (r >> 1) ^ 64'had93d23594c935a9;
            else r = r >> 1;
        end
        return r;
    endfunction

    // first matching code wins, a miss is reported via the return flag
    function automatic logic decode_type(logic [7:0] b, output logic [1:0] k);
        k = ssp_pkg::KIND_STRING;
        if (b == cfg_copy.t_str) k = ssp_pkg::KIND_STRING;
        else if (b == cfg_copy.t_list) k = ssp_pkg::KIND_LIST;
        else if (b == cfg_copy.t_hash) k = ssp_pkg::KIND_HASH;
        else if (b == cfg_copy.t_zset) k = ssp_pkg::KIND_ZSET;
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic void end_entry();
        m_keys = m_keys - 64'd1;
        m_phase = (m_keys == 64'd0) ? ssp_pkg::PH_CRC : ssp_pkg::PH_TYPE;
    endfunction

    function automatic void item_phase();
        if (m_kind == ssp_pkg::KIND_LIST) m_phase = ssp_pkg::PH_ELEMLEN;
        else if (m_kind == ssp_pkg::KIND_HASH) m_phase = ssp_pkg::PH_FIELDLEN;
        else m_phase = ssp_pkg::PH_SCORE;
    endfunction

    function automatic void end_item();
        m_elems = m_elems - 32'd1;
        if (m_elems == 32'd0) end_entry();
        else item_phase();
    endfunction

    function automatic void blob_finished(logic [4:0] ph);
        case (ph)
            ssp_pkg::PH_KEYBYTE: begin
                m_phase = (m_kind == ssp_pkg::KIND_STRING) ?
                          ssp_pkg::PH_VALLEN : ssp_pkg::PH_COUNT;
            end
            ssp_pkg::PH_VALBYTE: begin
                if (m_kind == ssp_pkg::KIND_HASH) begin
                    m_val_due = 1'b0;
                    end_item();
                end else begin
                    end_entry();
                end
            end
            ssp_pkg::PH_FIELDBYTE: begin
                m_val_due = 1'b1;
                m_phase = ssp_pkg::PH_VALLEN;
            end
            default: end_item();
        endcase
    endfunction

    function automatic void number_finished(logic [4:0] ph, logic [63:0] v);
        logic [1:0] k;
        case (ph)
            ssp_pkg::PH_MAGIC: begin
                if (v[31:0] != cfg_copy.magic_word) begin
                    m_status = ssp_pkg::ST_BAD_MAG;
                    m_phase = ssp_pkg::PH_DONE;
                end else m_phase = ssp_pkg::PH_VERSION;
            end
            ssp_pkg::PH_VERSION: begin
                if (v[31:0] != cfg_copy.format_version) begin
                    m_status = ssp_pkg::ST_BAD_VER;
                    m_phase = ssp_pkg::PH_DONE;
                end else m_phase = ssp_pkg::PH_KEYCOUNT;
            end
            ssp_pkg::PH_KEYCOUNT: begin
                m_keys = v;
                m_phase = (v == 64'd0) ? ssp_pkg::PH_CRC : ssp_pkg::PH_TYPE;
            end
            ssp_pkg::PH_TYPE: begin
                if (!decode_type(v[7:0], k)) begin
                    m_status = ssp_pkg::ST_BAD_TYPE;
                    m_phase = ssp_pkg::PH_DONE;
                end else begin
                    m_kind = k;
                    m_val_due = 1'b0;
                    m_phase = ssp_pkg::PH_EXPIRY;
                end
            end
            ssp_pkg::PH_EXPIRY: m_phase = ssp_pkg::PH_KEYLEN;
            ssp_pkg::PH_KEYLEN, ssp_pkg::PH_VALLEN,
            ssp_pkg::PH_ELEMLEN, ssp_pkg::PH_FIELDLEN: begin
                m_blob = v[31:0];
                if (m_blob == 32'd0) blob_finished(ph + 5'd1);
                else m_phase = ph + 5'd1;
            end
            ssp_pkg::PH_COUNT: begin
                m_elems = v[31:0];
                if (m_elems == 32'd0) end_entry();
                else item_phase();
            end
            ssp_pkg::PH_SCORE: m_phase = ssp_pkg::PH_ELEMLEN;
            default: begin
                m_status = (v == m_crc) ? ssp_pkg::ST_OK : ssp_pkg::ST_BAD_CRC;
                m_phase = ssp_pkg::PH_DONE;
            end
        endcase
    endfunction

    // expected tag for one accepted transaction, advances the predictor
    function automatic ssp_pkg::t_out tag_byte(ssp_pkg::t_in x);
        ssp_pkg::t_out r;
        logic [4:0] ph;
        logic [3:0] n;
        logic [3:0] w;
        logic [63:0] v;
        ph = m_phase;
        r.role = ssp_pkg::PH_DONE;
        r.data_out = x.end_of_input ? 8'd0 : x.data_in;
        r.field_last = 1'b0;
        r.field_value = '0;
        if (m_status != ssp_pkg::ST_BUSY || ph >= ssp_pkg::PH_DONE) begin
            r.status = m_status;
            return r;
        end
        if (x.end_of_input) begin
            if (ph == ssp_pkg::PH_MAGIC) m_status = ssp_pkg::ST_BAD_MAG;
            else if (ph == ssp_pkg::PH_VERSION) m_status = ssp_pkg::ST_BAD_VER;
            else if (ph == ssp_pkg::PH_CRC) m_status = ssp_pkg::ST_BAD_CRC;
            else m_status = ssp_pkg::ST_TRUNC;
            m_phase = ssp_pkg::PH_DONE;
            r.status = m_status;
            return r;
        end
        r.role = ph;
        if (ph != ssp_pkg::PH_CRC) m_crc = crc64_step(m_crc, x.data_in);
        if (ph == ssp_pkg::PH_KEYBYTE || ph == ssp_pkg::PH_VALBYTE ||
            ph == ssp_pkg::PH_ELEMBYTE || ph == ssp_pkg::PH_FIELDBYTE) begin
            m_blob = m_blob - 32'd1;
            if (m_blob == 32'd0) begin
                r.field_last = 1'b1;
                blob_finished(ph);
            end
        end else begin
            n = {1'b0, m_fcnt[2:0]};
            m_fshift = m_fshift | ({56'd0, x.data_in} << {n, 3'b000});
            n = n + 4'd1;
            if (ph == ssp_pkg::PH_TYPE) w = 4'd1;
            else if (ph == ssp_pkg::PH_KEYCOUNT || ph == ssp_pkg::PH_EXPIRY ||
                     ph == ssp_pkg::PH_SCORE || ph == ssp_pkg::PH_CRC) w = 4'd8;
            else w = 4'd4;
            if (n >= w) begin
                v = m_fshift;
                m_fcnt = '0;
                m_fshift = '0;
                r.field_last = 1'b1;
                r.field_value = v;
                number_finished(ph, v);
            end else m_fcnt = n;
        end
        r.status = m_status;
        return r;
    endfunction

    // ---------------- receiver side: stall and check ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (tagged_q.size() == 0) begin
                    $error("unexpected transaction role=%0d data=%h",
                           out_item.role, out_item.data_out);
                    mismatches++;
                end else begin
                    ssp_pkg::t_out e;
                    e = tagged_q.pop_front();
                    tags_checked++;
                    if (out_item.role !== e.role) begin
                        $error("role: expected %0d, got %0d", e.role, out_item.role);
                        mismatches++;
                    end
                    if (out_item.data_out !== e.data_out) begin
                        $error("data_out: expected %h, got %h", e.data_out, out_item.data_out);
                        mismatches++;
                    end
                    if (out_item.field_last !== e.field_last) begin
                        $error("field_last: expected %b, got %b",
                               e.field_last, out_item.field_last);
                        mismatches++;
                    end
                    if (out_item.field_value !== e.field_value) begin
                        $error("field_value: expected %h, got %h",
                               e.field_value, out_item.field_value);
                        mismatches++;
                    end
                    if (out_item.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, out_item.status);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("tb_snapshot_stream_parser_crc64: FAIL");
            $finish;
        end
    end

    // ---------------- sender side ----------------
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= '{data_in: b, end_of_input: eoi};
        do @(posedge i_clk); while (in_stall);
        tagged_q.push_back(tag_byte('{data_in: b, end_of_input: eoi}));
        bytes_sent++;
    endtask

    // let the block run dry: nothing outstanding, output register emptied
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (tagged_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            ssp_pkg::CFG_MAGIC:   cfg_copy.magic_word = val;
            ssp_pkg::CFG_VERSION: cfg_copy.format_version = val;
            ssp_pkg::CFG_T_STR:   cfg_copy.t_str = val[7:0];
            ssp_pkg::CFG_T_LIST:  cfg_copy.t_list = val[7:0];
            ssp_pkg::CFG_T_HASH:  cfg_copy.t_hash = val[7:0];
            default:              cfg_copy.t_zset = val[7:0];
        endcase
    endtask

    task automatic send_le(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++) send_byte(v[8*i +: 8], 1'b0);
    endtask

    task automatic send_blob(input int len);
        send_le(64'(len), 4);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    // one entry; the layout follows how the type byte decodes under the current codes
    task automatic send_entry(input logic [7:0] tbyte, input int maxlen, input int maxcnt,
                              input logic [63:0] expiry);
        logic [1:0] k;
        int cnt;
        void'(decode_type(tbyte, k));
        send_byte(tbyte, 1'b0);
        send_le(expiry, 8);
        send_blob($urandom_range(maxlen));
        if (k == ssp_pkg::KIND_STRING) begin
            send_blob($urandom_range(maxlen));
        end else begin
            cnt = $urandom_range(maxcnt);
            send_le(64'(cnt), 4);
            for (int i = 0; i < cnt; i++) begin
                if (k == ssp_pkg::KIND_ZSET) send_le({$urandom, $urandom}, 8);
                send_blob($urandom_range(maxlen));
                if (k == ssp_pkg::KIND_HASH) send_blob($urandom_range(maxlen));
            end
        end
    endtask

    // ---------------- tests ----------------
    // magic and version at their all-ones / all-zeros extremes
    task automatic test_header();
        write_reg(ssp_pkg::CFG_MAGIC, 32'hffff_ffff);
        write_reg(ssp_pkg::CFG_VERSION, 32'h0000_0000);
        send_le(64'hffff_ffff, 4);
        send_le(64'h0, 4);
        send_le(64'(DIRECTED_ENTRIES + RANDOM_ENTRIES), 8);
    endtask

    // entries of every kind, empty blobs and counts, overlapping type codes
    task automatic test_entry_kinds();
        write_reg(ssp_pkg::CFG_T_STR, 32'hff);
        write_reg(ssp_pkg::CFG_T_LIST, 32'h00);
        write_reg(ssp_pkg::CFG_T_HASH, 32'h80);
        write_reg(ssp_pkg::CFG_T_ZSET, 32'h7f);
        // magic and version are already checked, so these writes must not matter
        write_reg(ssp_pkg::CFG_MAGIC, 32'h0);
        write_reg(ssp_pkg::CFG_VERSION, 32'hffff_ffff);
        send_entry(8'hff, 0, 0, 64'hffff_ffff_ffff_ffff);   // empty key and value
        send_entry(8'h00, 0, 0, 64'h0);                     // list with zero count
        send_entry(8'h80, 3, 2, 64'h8000_0000_0000_0001);
        send_entry(8'h7f, 3, 2, {$urandom, $urandom});
        send_entry(8'h00, 2, 3, {$urandom, $urandom});
        // list code equal to the string code: string must win
        write_reg(ssp_pkg::CFG_T_LIST, 32'hff);
        send_entry(8'hff, 3, 2, {$urandom, $urandom});
        // zset code equal to the hash code: hash must win
        write_reg(ssp_pkg::CFG_T_LIST, 32'h00);
        write_reg(ssp_pkg::CFG_T_ZSET, 32'h80);
        send_entry(8'h80, 3, 2, {$urandom, $urandom});
    endtask

    // random entries under four idling phases, codes reshuffled per phase
    task automatic test_random_entries();
        logic [7:0] codes[4];
        for (int p = 0; p < 4; p++) begin
            codes[0] = 8'($urandom_range(255));
            do codes[1] = 8'($urandom_range(255)); while (codes[1] == codes[0]);
            do codes[2] = 8'($urandom_range(255));
            while (codes[2] == codes[0] || codes[2] == codes[1]);
            do codes[3] = 8'($urandom_range(255));
            while (codes[3] == codes[0] || codes[3] == codes[1] || codes[3] == codes[2]);
            write_reg(ssp_pkg::CFG_T_STR, {24'd0, codes[0]});
            write_reg(ssp_pkg::CFG_T_LIST, {24'd0, codes[1]});
            write_reg(ssp_pkg::CFG_T_HASH, {24'd0, codes[2]});
            write_reg(ssp_pkg::CFG_T_ZSET, {24'd0, codes[3]});
            case (p)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 87; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 87; end
                default: begin snd_idle_pct = 7; rcv_stall_pct = 7; end
            endcase
            for (int e = 0; e < RANDOM_ENTRIES / 4; e++)
                send_entry(codes[$urandom_range(3)], 6, 4, {$urandom, $urandom});
        end
        snd_idle_pct = 7;
        rcv_stall_pct = 7;
    endtask

    // checksum after a full pause, then trailing bytes and end markers are ignored
    task automatic test_checksum_and_tail();
        drain();
        send_le(m_crc, 8);
        for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(255)), i[0]);
    endtask

    initial begin
        cfg_copy = '{magic_word: 32'd0, format_version: 32'd1,
                     t_str: 8'd0, t_list: 8'd1, t_hash: 8'd2, t_zset: 8'd3};
        m_phase = ssp_pkg::PH_MAGIC;
        m_fcnt = '0;
        m_fshift = '0;
        m_keys = '0;
        m_elems = '0;
        m_blob = '0;
        m_kind = ssp_pkg::KIND_STRING;
        m_val_due = 1'b0;
        m_crc = '0;
        m_status = ssp_pkg::ST_BUSY;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header();
        test_entry_kinds();
        test_random_entries();
        test_checksum_and_tail();

        in_valid <= 1'b0;
        while (tagged_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("covered: header, %0d entries of all kinds, crc check, trailing bytes",
                 DIRECTED_ENTRIES + RANDOM_ENTRIES);
        $display("%0d bytes sent, %0d tags checked, final status %0d",
                 bytes_sent, tags_checked, m_status);
        if (mismatches == 0) begin
            $display("tb_snapshot_stream_parser_crc64: PASS");
        end else begin
            $display("tb_snapshot_stream_parser_crc64: FAIL");
        end
        $finish;
    end
endmodule
